>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on i_clk, quiet while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked on i_clk, also checked through reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/clkpr_pkg.sv
// Shared constants, types and state codes of the clock page replacement block.
`timescale 1ns / 1ps
package clkpr_pkg;

    localparam int FRAMES      = 8;
    localparam int PAGE_BITS   = 16;
    localparam int SLOT_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int TALLY_W     = 16;
    localparam int IN_W        = 16;
    localparam int OUT_TDATA_W = 40;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [TALLY_W-1:0]   t_tally;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_EVICT,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_slot rd_addr;
        logic  wr_en;
        t_slot wr_addr;
        t_page wr_data;
        t_page key;
    } t_store_req;

    typedef struct packed {
        logic   hit;
        t_slot  slot;
        logic   ev_valid;
        t_page  ev_page;
        t_tally faults;
    } t_result;

endpackage

>>> hw/rtl/clkpr_frame_store.sv
// Resident page memory with registered read and the shared page comparator.
`timescale 1ns / 1ps
module clkpr_frame_store (
    input  logic                  i_clk,
    input  clkpr_pkg::t_store_req i_req,
    output clkpr_pkg::t_page      o_rd_data,
    output logic                  o_match
);
    import clkpr_pkg::*;

    t_page r_mem [FRAMES];
    t_page r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_match   = (r_rd_data == i_req.key);

endmodule

>>> hw/rtl/clkpr_seq.sv
// Sequencer: serial lookup, free-frame fill, clock sweep and eviction.
`timescale 1ns / 1ps
module clkpr_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  clkpr_pkg::t_page      i_page,
    output logic                  o_ready,
    output clkpr_pkg::t_store_req o_req,
    input  clkpr_pkg::t_page      i_rd_data,
    input  logic                  i_match,
    input  logic                  i_out_free,
    output logic                  o_emit,
    output clkpr_pkg::t_result    o_res
);
    import clkpr_pkg::*;

    localparam t_slot LAST = SLOT_W'(FRAMES - 1);

    function automatic t_slot f_next(input t_slot s);
        f_next = (s == LAST) ? '0 : s + 1'b1;
    endfunction

    t_state            r_state, n_state;
    logic [FRAMES-1:0] r_valid, n_valid;
    logic [FRAMES-1:0] r_use, n_use;
    t_slot             r_hand, n_hand;
    t_tally            r_tally, n_tally;
    logic              r_issue, n_issue;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_have_free, n_have_free;
    t_slot             r_idx, n_idx;
    t_slot             r_cmp_idx, n_cmp_idx;
    t_slot             r_free, n_free;
    t_page             r_page, n_page;
    t_result           r_res, n_res;

    logic   cur_valid;
    t_slot  free_slot;
    t_tally tally_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_use       <= '0;
            r_hand      <= '0;
            r_tally     <= '0;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_use       <= n_use;
            r_hand      <= n_hand;
            r_tally     <= n_tally;
            r_issue     <= n_issue;
            r_cmp_vld   <= n_cmp_vld;
            r_have_free <= n_have_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_free    <= n_free;
        r_page    <= n_page;
        r_res     <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_use       = r_use;
        n_hand      = r_hand;
        n_tally     = r_tally;
        n_issue     = r_issue;
        n_cmp_vld   = r_cmp_vld;
        n_have_free = r_have_free;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_free      = r_free;
        n_page      = r_page;
        n_res       = r_res;

        o_ready       = 1'b0;
        o_emit        = 1'b0;
        o_req.rd_addr = r_idx;
        o_req.wr_en   = 1'b0;
        o_req.wr_addr = r_hand;
        o_req.wr_data = r_page;
        o_req.key     = r_page;

        cur_valid = r_valid[r_cmp_idx];
        free_slot = r_have_free ? r_free : r_cmp_idx;
        tally_inc = (r_tally == '1) ? r_tally : r_tally + 1'b1;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_page      = i_page;
                    n_idx       = '0;
                    n_issue     = 1'b1;
                    n_cmp_vld   = 1'b0;
                    n_have_free = 1'b0;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                // read of slot r_idx overlaps compare of slot r_cmp_idx
                n_cmp_vld = r_issue;
                if (r_issue) begin
                    n_cmp_idx = r_idx;
                    if (r_idx == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    if (cur_valid && i_match) begin
                        n_use[r_cmp_idx] = 1'b1;
                        n_res     = '{hit: 1'b1, slot: r_cmp_idx, ev_valid: 1'b0,
                                      ev_page: '0, faults: r_tally};
                        n_issue   = 1'b0;
                        n_cmp_vld = 1'b0;
                        n_state   = S_EMIT;
                    end else begin
                        if (!cur_valid && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free      = r_cmp_idx;
                        end
                        if (r_cmp_idx == LAST) begin
                            n_cmp_vld = 1'b0;
                            if (r_have_free || !cur_valid) begin
                                o_req.wr_en        = 1'b1;
                                o_req.wr_addr      = free_slot;
                                n_valid[free_slot] = 1'b1;
                                n_use[free_slot]   = 1'b1;
                                n_res   = '{hit: 1'b0, slot: free_slot, ev_valid: 1'b0,
                                            ev_page: '0, faults: r_tally};
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                    end
                end
            end
            S_SWEEP: begin
                o_req.rd_addr = r_hand;
                if (r_use[r_hand]) begin
                    n_use[r_hand] = 1'b0;
                    n_hand        = f_next(r_hand);
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                o_req.rd_addr    = r_hand;
                o_req.wr_en      = 1'b1;
                o_req.wr_addr    = r_hand;
                n_use[r_hand]    = 1'b1;
                n_hand           = f_next(r_hand);
                n_tally          = tally_inc;
                n_res   = '{hit: 1'b0, slot: r_hand, ev_valid: 1'b1,
                            ev_page: i_rd_data, faults: tally_inc};
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

>>> hw/rtl/clock_page_replacement_top.sv
// Top level of the clock (second-chance) page replacement block.
// One page reference is taken at a time; o_s_tready is high only while the block is idle.
// A reference is looked up by reading the resident page memory one frame per cycle through a
// single comparator; a hit stops the scan at the matching frame, and a miss scans all frames.
// A miss with a free frame then takes the first free frame. When all frames are full the clock
// hand steps one frame per cycle, clearing use bits, until it finds a clear one, and the evict
// state then replaces that frame. A result waits in the output register until taken.
`timescale 1ns / 1ps
module clock_page_replacement_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] page_number
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [0] hit, [3:1] frame_slot, [4] evicted_valid,
                                     // [20:5] evicted_page, [36:21] replace_faults, [39:37] 0
);
    import clkpr_pkg::*;

    t_store_req store_req;
    t_page      rd_data;
    logic       match;
    logic       seq_ready;
    logic       emit;
    t_result    res;
    logic       out_free;
    logic       r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = seq_ready;

    clkpr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_s_tvalid && seq_ready),
        .i_page     (PAGE_BITS'(i_s_tdata[IN_W-1:0])),
        .o_ready    (seq_ready),
        .o_req      (store_req),
        .i_rd_data  (rd_data),
        .i_match    (match),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_res      (res)
    );

    clkpr_frame_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data),
        .o_match   (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {3'b000, 16'(res.faults), 16'(res.ev_page), res.ev_valid,
                           3'(res.slot), res.hit};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> hw/rtl/clkpr_checker.sv
// Port-level checker for the clock page replacement block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clkpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    `ASSERT_CLK(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")
    `ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_busy, i_s_tvalid && o_s_tready |=> !o_s_tready, "ready high while a request is in work")
    `ASSERT_CLK(a_hit_no_evict, o_m_tvalid && o_m_tdata[0] |-> !o_m_tdata[4], "eviction reported on a hit")
    `ASSERT_CLK(a_evict_page, o_m_tvalid && !o_m_tdata[4] |-> o_m_tdata[20:5] == 16'd0, "evicted page nonzero without eviction")

endmodule

bind clock_page_replacement_top clkpr_checker u_clkpr_checker (.*);

>>> tb/clock_page_replacement_top_test.sv
// Self-checking testbench of the clock page replacement block with its own clock predictor.
`timescale 1ns / 1ps
module clock_page_replacement_top_test;
    import clkpr_pkg::*;

    localparam int     CYCLE_LIMIT = 8_000_000;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     MAX_REPORTS = 10;
    localparam t_tally TALLY_CEIL  = '1;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;     // [15:0] page_number
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;        // [0] hit, [3:1] frame_slot, [4] evicted_valid,
                                   // [20:5] evicted_page, [36:21] replace_faults

    // predictor state
    t_page   frame_page [FRAMES];
    bit      frame_live [FRAMES];
    bit      ref_bit [FRAMES];
    int      hand_pos = 0;
    t_tally  fault_tally = '0;

    t_result pending_outcomes [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      steady_flow = 1'b0;
    int      stall_left = 0;

    clock_page_replacement_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("clock_page_replacement_top verification failed");
            $finish;
        end
    end

    function automatic t_result clock_lookup(input t_page pg);
        t_result r;
        bit      found;
        int      k;
        int      steps;
        r = '0;
        found = 1'b0;
        for (k = 0; k < FRAMES; k++) begin
            if (!found && frame_live[k] && frame_page[k] == pg) begin
                found = 1'b1;
                r.slot = t_slot'(k);
            end
        end
        if (found) begin
            r.hit = 1'b1;
            ref_bit[r.slot] = 1'b1;
        end else begin
            for (k = 0; k < FRAMES; k++) begin
                if (!found && !frame_live[k]) begin
                    found = 1'b1;
                    r.slot = t_slot'(k);
                end
            end
            if (found) begin
                frame_page[r.slot] = pg;
                frame_live[r.slot] = 1'b1;
                ref_bit[r.slot] = 1'b1;
            end else begin
                // second chance: clear set bits until a clear one turns up
                steps = 0;
                while (ref_bit[hand_pos] && steps < 2 * FRAMES + 1) begin
                    ref_bit[hand_pos] = 1'b0;
                    hand_pos = (hand_pos + 1) % FRAMES;
                    steps++;
                end
                r.slot = t_slot'(hand_pos);
                r.ev_valid = 1'b1;
                r.ev_page = frame_page[hand_pos];
                frame_page[hand_pos] = pg;
                ref_bit[hand_pos] = 1'b1;
                hand_pos = (hand_pos + 1) % FRAMES;
                if (fault_tally != TALLY_CEIL)
                    fault_tally++;
            end
        end
        r.faults = fault_tally;
        return r;
    endfunction

    function automatic int pick_pause();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    task automatic log_mismatch(input string note, input t_result want, input logic [39:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s: expected hit=%0b slot=%0d ev=%0b ev_page=%h faults=%0d, got hit=%0b slot=%0d ev=%0b ev_page=%h faults=%0d pad=%0b",
                     note, want.hit, want.slot, want.ev_valid, want.ev_page, want.faults,
                     got[0], got[3:1], got[4], got[20:5], got[36:21], got[39:37]);
    endtask

    // result side: random stalls, compare each taken result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (rst_n && m_tready && o_m_tvalid) begin
            if (pending_outcomes.size() == 0) begin
                log_mismatch("unexpected result", '0, o_m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_m_tdata[0] !== want.hit || o_m_tdata[3:1] !== want.slot ||
                    o_m_tdata[4] !== want.ev_valid || o_m_tdata[20:5] !== want.ev_page ||
                    o_m_tdata[36:21] !== want.faults || o_m_tdata[39:37] !== 3'b000)
                    log_mismatch("result mismatch", want, o_m_tdata);
            end
        end
        if (stall_left == 0 && !steady_flow && $urandom_range(0, 3) == 0)
            stall_left = pick_pause();
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_page(input t_page pg);
        int gap;
        gap = steady_flow ? 0 : (($urandom_range(0, 2) == 0) ? 0 : pick_pause());
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pg;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        pending_outcomes.push_back(clock_lookup(pg));
    endtask

    task automatic test_directed_cases();
        steady_flow = 1'b0;
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0003);
        send_page(16'h8000);
        send_page(16'h8000);   // hit in the last frame
        send_page(16'hFFFF);
        send_page(16'h1234);   // all use bits set: full sweep wraps around
        send_page(16'h4321);   // hand lands on a clear bit at once
        send_page(16'h1234);
        send_page(16'h5555);
        send_page(16'h7777);   // one set bit cleared, then replace
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0003);
        send_page(16'h7FFF);
    endtask

    task automatic test_random_traffic();
        t_page pool [12];
        int    n;
        int    set_size;
        foreach (pool[j]) pool[j] = t_page'($urandom);
        set_size = 8;
        for (n = 0; n < 1350; n++) begin
            if (n % 100 == 0) begin
                steady_flow = ($urandom_range(0, 3) == 0);
                set_size = $urandom_range(4, 12);
            end
            if ($urandom_range(0, 15) == 0)
                pool[$urandom_range(0, 11)] = t_page'($urandom);
            if ($urandom_range(0, 9) == 0)
                send_page(t_page'($urandom));
            else
                send_page(pool[$urandom_range(0, set_size - 1)]);
        end
    endtask

    // re-reference resident pages between fresh misses
    task automatic test_resident_rehits();
        int n;
        steady_flow = 1'b0;
        for (n = 0; n < 30; n++) begin
            if (n % 3 == 0)
                send_page(frame_page[$urandom_range(0, FRAMES - 1)]);
            else
                send_page(t_page'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic();
        test_resident_rehits();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("clock_page_replacement_top verification clean");
        else
            $display("clock_page_replacement_top verification failed");
        $finish;
    end

endmodule
